### rtl/sisc_pkg.sv
// shared types and codes for the staged inactivity sleep controller
// no dependencies

package sisc_pkg;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] activity_source;
    logic [2:0] wake_reason;
    logic [3:0] blocker_code;
  } sisc_in_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  action;
    logic [2:0]  event_reason;
    logic [1:0]  stage_now;
    logic        armed_now;
    logic        blocked_now;
    logic [3:0]  blocker_now;
    logic [2:0]  last_reason;
    logic [15:0] idle_seconds;
    logic [15:0] display_seconds_left;
    logic [15:0] light_seconds_left;
    logic        ready_res;
  } sisc_out_t;

  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_INIT        = 3'd1;
  localparam logic [2:0] CMD_APPLY       = 3'd2;
  localparam logic [2:0] CMD_NO_MOTION   = 3'd3;
  localparam logic [2:0] CMD_ACTIVITY    = 3'd4;
  localparam logic [2:0] CMD_LIGHT_WAKE  = 3'd5;

  localparam logic [1:0] SRC_MOTION      = 2'd2;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_DISP_SLEEP  = 3'd1;
  localparam logic [2:0] ACT_DISP_WAKE   = 3'd2;
  localparam logic [2:0] ACT_LIGHT_SLEEP = 3'd3;
  localparam logic [2:0] ACT_LIGHT_WAKE  = 3'd4;

  localparam logic [2:0] RSN_NONE        = 3'd0;
  localparam logic [2:0] RSN_INACTIVITY  = 3'd1;
  localparam logic [2:0] RSN_MOTION      = 3'd2;
  localparam logic [2:0] RSN_INTERACTION = 3'd3;
  localparam logic [2:0] RSN_SETTINGS    = 3'd4;

  localparam logic [1:0] STG_AWAKE       = 2'd0;
  localparam logic [1:0] STG_DISPLAY     = 2'd1;
  localparam logic [1:0] STG_LIGHT       = 2'd2;

  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_DISP        = 3'd1;
  localparam logic [2:0] REG_LIGHT       = 3'd2;
  localparam logic [2:0] REG_MOTION_WAKE = 3'd3;
  localparam logic [2:0] REG_INTER_WAKE  = 3'd4;

endpackage

### rtl/staged_inactivity_sleep_controller.sv
// staged inactivity sleep controller: input register, command logic, result register
// depends on sisc_pkg
//
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | in_data   (sisc_in_t)
//   out     | out_valid / out_stall   | out_data  (sisc_out_t)
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one item per cycle while out is not stalled; each item is held in the input register, then in the result register
// the command logic sits between the input register and the result register
// rst_n is synchronous; it clears state, settings, registers and both valid flags
// a stall on out holds the result; the input register keeps taking items while it can move on
// cfg_ready is always high; staged registers take effect only on the apply command

module staged_inactivity_sleep_controller #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sisc_pkg::sisc_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sisc_pkg::sisc_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  import sisc_pkg::*;

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // staged registers
  logic        reg_en_r, reg_mw_r, reg_iw_r;
  logic [15:0] reg_disp_r, reg_light_r;
  // active settings
  logic        act_en_r, act_mw_r, act_iw_r;
  logic [15:0] act_disp_r, act_light_r;
  logic        act_en_nxt, act_mw_nxt, act_iw_nxt;
  logic [15:0] act_disp_nxt, act_light_nxt;

  logic [1:0]            stage_r, stage_nxt;
  logic                  armed_r, armed_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [3:0]            blk_r, blk_nxt;
  logic [2:0]            trsn_r, trsn_nxt;
  logic                  init_r, init_nxt;

  logic      s1_valid_r;
  sisc_in_t  s1_r;
  logic      s1_adv;
  logic      out_valid_r;
  sisc_out_t out_r, out_nxt;

  logic        status, motion;
  logic [2:0]  action, ereason, wreason;
  logic [CW-1:0] cnt_ext, disp_ext, light_ext;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    act_en_nxt    = act_en_r;
    act_disp_nxt  = act_disp_r;
    act_light_nxt = act_light_r;
    act_mw_nxt    = act_mw_r;
    act_iw_nxt    = act_iw_r;
    stage_nxt     = stage_r;
    armed_nxt     = armed_r;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    trsn_nxt      = trsn_r;
    init_nxt      = init_r;
    status        = 1'b0;
    action        = ACT_NONE;
    ereason       = RSN_NONE;
    motion        = (s1_r.activity_source == SRC_MOTION);
    wreason       = (s1_r.wake_reason > RSN_SETTINGS) ? RSN_NONE : s1_r.wake_reason;
    disp_ext      = CW'(act_disp_r);
    light_ext     = CW'(act_light_r);
    cnt_ext       = '0;
    case (s1_r.command)
      CMD_TICK: begin
        blk_nxt = s1_r.blocker_code;
        if (s1_r.blocker_code != 4'd0 && armed_r) begin
          cnt_nxt = '0;
        end
        if (init_r && act_en_r && armed_r && s1_r.blocker_code == 4'd0) begin
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          cnt_ext = CW'(cnt_nxt);
          if (act_light_r != 16'd0 && cnt_ext >= light_ext && stage_r == STG_DISPLAY) begin
            stage_nxt = STG_LIGHT;
            trsn_nxt  = RSN_INACTIVITY;
            action    = ACT_LIGHT_SLEEP;
            ereason   = RSN_INACTIVITY;
          end else if (act_disp_r != 16'd0 && cnt_ext >= disp_ext &&
                       stage_r == STG_AWAKE) begin
            stage_nxt = STG_DISPLAY;
            trsn_nxt  = RSN_INACTIVITY;
            action    = ACT_DISP_SLEEP;
            ereason   = RSN_INACTIVITY;
          end
        end
      end
      CMD_INIT: begin
        if (!init_r) begin
          if (act_disp_r != 16'd0 && act_light_r != 16'd0 && act_light_r < act_disp_r) begin
            status = 1'b1;
          end else begin
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
            stage_nxt = STG_AWAKE;
            trsn_nxt  = RSN_NONE;
            blk_nxt   = 4'd0;
            init_nxt  = 1'b1;
          end
        end
      end
      CMD_APPLY: begin
        if (reg_disp_r != 16'd0 && reg_light_r != 16'd0 && reg_light_r < reg_disp_r) begin
          status = 1'b1;
        end else begin
          act_en_nxt    = reg_en_r;
          act_disp_nxt  = reg_disp_r;
          act_light_nxt = reg_light_r;
          act_mw_nxt    = reg_mw_r;
          act_iw_nxt    = reg_iw_r;
          ereason       = RSN_SETTINGS;
          if (!reg_en_r && stage_r != STG_AWAKE) begin
            action    = (stage_r == STG_LIGHT) ? ACT_LIGHT_WAKE : ACT_DISP_WAKE;
            stage_nxt = STG_AWAKE;
            trsn_nxt  = RSN_SETTINGS;
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
          end
        end
      end
      CMD_NO_MOTION: begin
        if (!init_r || !act_en_r || stage_r != STG_AWAKE || armed_r) begin
          status = 1'b1;
        end else begin
          armed_nxt = 1'b1;
          cnt_nxt   = '0;
          blk_nxt   = s1_r.blocker_code;
        end
      end
      CMD_ACTIVITY: begin
        armed_nxt = 1'b0;
        cnt_nxt   = '0;
        if (stage_r == STG_LIGHT && !motion && act_iw_r) begin
          stage_nxt = STG_AWAKE;
          trsn_nxt  = RSN_INTERACTION;
          action    = ACT_LIGHT_WAKE;
          ereason   = RSN_INTERACTION;
        end else if (stage_r == STG_DISPLAY &&
                     ((motion && act_mw_r) || (!motion && act_iw_r))) begin
          stage_nxt = STG_AWAKE;
          trsn_nxt  = motion ? RSN_MOTION : RSN_INTERACTION;
          action    = ACT_DISP_WAKE;
          ereason   = motion ? RSN_MOTION : RSN_INTERACTION;
        end
      end
      CMD_LIGHT_WAKE: begin
        if (stage_r != STG_LIGHT) begin
          status = 1'b1;
        end else begin
          stage_nxt = STG_AWAKE;
          trsn_nxt  = wreason;
          armed_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase

    // snapshot after the update
    cnt_ext       = CW'(cnt_nxt);
    disp_ext      = CW'(act_disp_nxt);
    light_ext     = CW'(act_light_nxt);
    out_nxt.status       = status;
    out_nxt.action       = action;
    out_nxt.event_reason = ereason;
    out_nxt.stage_now    = stage_nxt;
    out_nxt.armed_now    = armed_nxt;
    out_nxt.blocked_now  = (blk_nxt != 4'd0);
    out_nxt.blocker_now  = blk_nxt;
    out_nxt.last_reason  = trsn_nxt;
    out_nxt.ready_res    = init_nxt;
    if (!armed_nxt) begin
      out_nxt.idle_seconds = 16'd0;
    end else if (cnt_ext > CW'(16'hFFFF)) begin
      out_nxt.idle_seconds = 16'hFFFF;
    end else begin
      out_nxt.idle_seconds = cnt_ext[15:0];
    end
    if (!armed_nxt) begin
      out_nxt.display_seconds_left = act_disp_nxt;
    end else if (act_disp_nxt == 16'd0 || cnt_ext >= disp_ext) begin
      out_nxt.display_seconds_left = 16'd0;
    end else begin
      out_nxt.display_seconds_left = act_disp_nxt - cnt_ext[15:0];
    end
    if (!armed_nxt) begin
      out_nxt.light_seconds_left = act_light_nxt;
    end else if (act_light_nxt == 16'd0 || cnt_ext >= light_ext) begin
      out_nxt.light_seconds_left = 16'd0;
    end else begin
      out_nxt.light_seconds_left = act_light_nxt - cnt_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_en_r    <= 1'b0;
      reg_disp_r  <= 16'd0;
      reg_light_r <= 16'd0;
      reg_mw_r    <= 1'b0;
      reg_iw_r    <= 1'b0;
      act_en_r    <= 1'b0;
      act_disp_r  <= 16'd0;
      act_light_r <= 16'd0;
      act_mw_r    <= 1'b0;
      act_iw_r    <= 1'b0;
      stage_r     <= STG_AWAKE;
      armed_r     <= 1'b0;
      cnt_r       <= '0;
      blk_r       <= 4'd0;
      trsn_r      <= RSN_NONE;
      init_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:      reg_en_r    <= cfg_data[0];
          REG_DISP:        reg_disp_r  <= cfg_data;
          REG_LIGHT:       reg_light_r <= cfg_data;
          REG_MOTION_WAKE: reg_mw_r    <= cfg_data[0];
          REG_INTER_WAKE:  reg_iw_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (s1_adv) begin
        act_en_r    <= act_en_nxt;
        act_disp_r  <= act_disp_nxt;
        act_light_r <= act_light_nxt;
        act_mw_r    <= act_mw_nxt;
        act_iw_r    <= act_iw_nxt;
        stage_r     <= stage_nxt;
        armed_r     <= armed_nxt;
        cnt_r       <= cnt_nxt;
        blk_r       <= blk_nxt;
        trsn_r      <= trsn_nxt;
        init_r      <= init_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(init_r))
    else $error("initialized flag cleared outside reset");

  a_armed_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> init_r)
    else $error("counter armed before init");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (cnt_r == '0))
    else $error("inactivity count nonzero while disarmed");

  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule

### tb/sv/tb_staged_inactivity_sleep_controller.sv
// self-checking testbench for the staged inactivity sleep controller
// predicts every result from its own model of stages, counter and settings
// depends on sisc_pkg and rtl/staged_inactivity_sleep_controller.sv

module tb_staged_inactivity_sleep_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import sisc_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO    = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI    = 3'd7;
  localparam logic [1:0] SRC_UNKNOWN     = 2'd0;
  localparam logic [1:0] SRC_INTERACTION = 2'd1;
  localparam logic [1:0] SRC_OTHER       = 2'd3;
  localparam logic [2:0] RSN_BAD         = 3'd7;
  localparam logic [3:0] BLK_NONE        = 4'd0;

  class sleep_ctrl_scoreboard;
    bit        stg_enable, stg_motion, stg_inter;
    bit [15:0] stg_disp, stg_light;
    bit        run_enable, run_motion, run_inter;
    bit [15:0] run_disp, run_light;
    bit [1:0]  stage;
    bit        armed;
    bit [15:0] idle_secs;
    bit [3:0]  blocker;
    bit [2:0]  last_rsn;
    bit        ready;
    sisc_out_t expected_q[$];
    int        errors, shown, accepted, checked;
    int        disp_sleeps, light_sleeps, wakes, refused;
    bit [15:0] peak_secs;

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_ENABLE:      stg_enable = val[0];
        REG_DISP:        stg_disp = val;
        REG_LIGHT:       stg_light = val;
        REG_MOTION_WAKE: stg_motion = val[0];
        REG_INTER_WAKE:  stg_inter = val[0];
        default: ;
      endcase
    endfunction

    function bit [15:0] secs_left(bit [15:0] tmo);
      if (!armed) return tmo;
      if (tmo == 16'd0 || idle_secs >= tmo) return 16'd0;
      return tmo - idle_secs;
    endfunction

    function void take_blocker(logic [3:0] code);
      blocker = code;
      if (code != BLK_NONE && armed) idle_secs = 16'd0;
    endfunction

    function bit move_to(logic [1:0] nxt, logic [2:0] act, logic [2:0] rsn);
      if (stage == nxt) return 1'b0;
      stage = nxt;
      last_rsn = rsn;
      if (act == ACT_DISP_WAKE || act == ACT_LIGHT_WAKE) begin
        armed = 1'b0;
        idle_secs = 16'd0;
      end
      return 1'b1;
    endfunction

    function void note_input(sisc_in_t it);
      sisc_out_t  res;
      bit         motion;
      logic [2:0] rsn;
      res = '0;
      case (it.command)
        CMD_TICK: begin
          take_blocker(it.blocker_code);
          if (ready && run_enable && armed && blocker == BLK_NONE) begin
            // counter holds at its maximum
            if (idle_secs != 16'hFFFF) idle_secs++;
            if (run_light != 0 && idle_secs >= run_light && stage == STG_DISPLAY) begin
              if (move_to(STG_LIGHT, ACT_LIGHT_SLEEP, RSN_INACTIVITY))
                res.action = ACT_LIGHT_SLEEP;
            end else if (run_disp != 0 && idle_secs >= run_disp && stage == STG_AWAKE) begin
              if (move_to(STG_DISPLAY, ACT_DISP_SLEEP, RSN_INACTIVITY))
                res.action = ACT_DISP_SLEEP;
            end
            if (res.action != ACT_NONE) res.event_reason = RSN_INACTIVITY;
          end
        end
        CMD_INIT: begin
          if (!ready) begin
            if (run_disp != 0 && run_light != 0 && run_light < run_disp) begin
              res.status = 1'b1;
            end else begin
              armed = 1'b0;
              idle_secs = 16'd0;
              stage = STG_AWAKE;
              last_rsn = RSN_NONE;
              blocker = BLK_NONE;
              ready = 1'b1;
            end
          end
        end
        CMD_APPLY: begin
          if (stg_disp != 0 && stg_light != 0 && stg_light < stg_disp) begin
            res.status = 1'b1;
          end else begin
            run_enable = stg_enable;
            run_disp = stg_disp;
            run_light = stg_light;
            run_motion = stg_motion;
            run_inter = stg_inter;
            if (!run_enable && stage != STG_AWAKE) begin
              res.action = (stage == STG_LIGHT) ? ACT_LIGHT_WAKE : ACT_DISP_WAKE;
              void'(move_to(STG_AWAKE, res.action, RSN_SETTINGS));
            end
            res.event_reason = RSN_SETTINGS;
          end
        end
        CMD_NO_MOTION: begin
          if (!ready || !run_enable || stage != STG_AWAKE || armed) begin
            res.status = 1'b1;
          end else begin
            armed = 1'b1;
            idle_secs = 16'd0;
            take_blocker(it.blocker_code);
          end
        end
        CMD_ACTIVITY: begin
          motion = (it.activity_source == SRC_MOTION);
          rsn = motion ? RSN_MOTION : RSN_INTERACTION;
          armed = 1'b0;
          idle_secs = 16'd0;
          if (stage == STG_LIGHT && !motion && run_inter) begin
            if (move_to(STG_AWAKE, ACT_LIGHT_WAKE, rsn)) res.action = ACT_LIGHT_WAKE;
          end else if (stage == STG_DISPLAY && (motion ? run_motion : run_inter)) begin
            if (move_to(STG_AWAKE, ACT_DISP_WAKE, rsn)) res.action = ACT_DISP_WAKE;
          end
          if (res.action != ACT_NONE) res.event_reason = rsn;
        end
        CMD_LIGHT_WAKE: begin
          if (stage != STG_LIGHT) begin
            res.status = 1'b1;
          end else begin
            void'(move_to(STG_AWAKE, ACT_LIGHT_WAKE,
                          (it.wake_reason > RSN_SETTINGS) ? RSN_NONE : it.wake_reason));
          end
        end
        default: res.status = 1'b1;
      endcase

      res.stage_now = stage;
      res.armed_now = armed;
      res.blocked_now = (blocker != BLK_NONE);
      res.blocker_now = blocker;
      res.last_reason = last_rsn;
      res.idle_seconds = armed ? idle_secs : 16'd0;
      res.display_seconds_left = secs_left(run_disp);
      res.light_seconds_left = secs_left(run_light);
      res.ready_res = ready;

      if (res.status) refused++;
      case (res.action)
        ACT_DISP_SLEEP:                disp_sleeps++;
        ACT_LIGHT_SLEEP:               light_sleeps++;
        ACT_DISP_WAKE, ACT_LIGHT_WAKE: wakes++;
        default: ;
      endcase
      if (armed && idle_secs > peak_secs) peak_secs = idle_secs;
      expected_q.push_back(res);
      accepted++;
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want && shown < 60) begin
        shown++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sisc_out_t got);
      sisc_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        field_check("status", 16'(want.status), 16'(got.status));
        field_check("action", 16'(want.action), 16'(got.action));
        field_check("event_reason", 16'(want.event_reason), 16'(got.event_reason));
        field_check("stage_now", 16'(want.stage_now), 16'(got.stage_now));
        field_check("armed_now", 16'(want.armed_now), 16'(got.armed_now));
        field_check("blocked_now", 16'(want.blocked_now), 16'(got.blocked_now));
        field_check("blocker_now", 16'(want.blocker_now), 16'(got.blocker_now));
        field_check("last_reason", 16'(want.last_reason), 16'(got.last_reason));
        field_check("idle_seconds", want.idle_seconds, got.idle_seconds);
        field_check("display_seconds_left", want.display_seconds_left,
                    got.display_seconds_left);
        field_check("light_seconds_left", want.light_seconds_left, got.light_seconds_left);
        field_check("ready_res", 16'(want.ready_res), 16'(got.ready_res));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sisc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sisc_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sleep_ctrl_scoreboard sb;
  bit          steady_send;
  int          burst_left;
  int          hold_asked, hold_done, hold_left;
  int          rcv_mode, rcv_left;
  int unsigned rcv_cyc;

  staged_inactivity_sleep_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_staged_inactivity_sleep_controller failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern plus an occasional long hold-off
  always @(posedge clk) begin
    rcv_cyc++;
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_left = $urandom_range(50, 300);
    end else begin
      rcv_left--;
    end
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = 64;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rcv_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (rcv_cyc % 5 < 2);
      endcase
    end
  end

  function automatic sisc_in_t mk(logic [2:0] cmd, logic [1:0] src, logic [2:0] wr,
                                  logic [3:0] blk);
    sisc_in_t it;
    it.command = cmd;
    it.activity_source = src;
    it.wake_reason = wr;
    it.blocker_code = blk;
    return it;
  endfunction

  function automatic sisc_in_t any_item(logic [2:0] cmd, logic [3:0] blk);
    return mk(cmd, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), blk);
  endfunction

  function automatic logic [3:0] rare_blocker(int odds);
    return ($urandom_range(0, odds) == 0) ? 4'($urandom_range(1, 15)) : BLK_NONE;
  endfunction

  task automatic send(sisc_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
    if (!steady_send) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(bit en, bit [15:0] disp, bit [15:0] light, bit mw, bit iw);
    write_reg(REG_ENABLE, 16'(en));
    write_reg(REG_DISP, disp);
    write_reg(REG_LIGHT, light);
    write_reg(REG_MOTION_WAKE, 16'(mw));
    write_reg(REG_INTER_WAKE, 16'(iw));
  endtask

  // mostly arm, tick and wake sequences, the rest random noise
  task automatic run_random(int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          send(any_item(CMD_INIT, BLK_NONE));
          sent++;
        end
        send(any_item(CMD_NO_MOTION, rare_blocker(5)));
        k = $urandom_range(0, 9);
        repeat (k) send(any_item(CMD_TICK, rare_blocker(11)));
        case ($urandom_range(0, 5))
          0:       send(any_item(CMD_ACTIVITY, BLK_NONE));
          1:       send(any_item(CMD_LIGHT_WAKE, BLK_NONE));
          2:       send(any_item(CMD_APPLY, BLK_NONE));
          3:       send(mk(CMD_ACTIVITY, SRC_MOTION, 3'($urandom_range(0, 7)), BLK_NONE));
          4:       send(mk(CMD_ACTIVITY, SRC_INTERACTION, 3'($urandom_range(0, 7)),
                        BLK_NONE));
          default: ;
        endcase
        sent += k + 2;
      end else begin
        send(mk(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))));
        sent++;
      end
    end
  endtask

  task automatic run_phase(bit en, bit [15:0] disp, bit [15:0] light, bit mw, bit iw,
                           int n, bit squeeze);
    drain();
    write_settings(en, disp, light, mw, iw);
    if (squeeze) hold_asked <= hold_asked + 1;
    steady_send = squeeze;
    send(any_item(CMD_APPLY, BLK_NONE));
    run_random(n);
    steady_send = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before init
    send(mk(CMD_TICK, SRC_UNKNOWN, RSN_NONE, 4'd15));
    send(mk(CMD_NO_MOTION, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_SPARE_LO, SRC_OTHER, RSN_BAD, 4'd15));
    send(mk(CMD_SPARE_HI, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_LIGHT_WAKE, SRC_UNKNOWN, RSN_MOTION, BLK_NONE));
    send(mk(CMD_ACTIVITY, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_INIT, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_INIT, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    drain();

    // full walk through both sleep stages, interaction wakes from both stages and the light wake command
    write_settings(1'b1, 16'd2, 16'd3, 1'b1, 1'b1);
    send(mk(CMD_APPLY, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_NO_MOTION, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_NO_MOTION, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    repeat (3) send(mk(CMD_TICK, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_ACTIVITY, SRC_MOTION, RSN_NONE, BLK_NONE));
    send(mk(CMD_ACTIVITY, SRC_INTERACTION, RSN_NONE, BLK_NONE));
    send(mk(CMD_NO_MOTION, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_TICK, SRC_UNKNOWN, RSN_NONE, 4'd9));
    repeat (2) send(mk(CMD_TICK, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_LIGHT_WAKE, SRC_UNKNOWN, RSN_INTERACTION, BLK_NONE));
    send(mk(CMD_ACTIVITY, SRC_OTHER, RSN_NONE, BLK_NONE));
    send(mk(CMD_NO_MOTION, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    repeat (3) send(mk(CMD_TICK, SRC_UNKNOWN, RSN_NONE, BLK_NONE));
    send(mk(CMD_LIGHT_WAKE, SRC_UNKNOWN, RSN_BAD, BLK_NONE));

    run_phase(1'b1, 16'd1, 16'd1, 1'b1, 1'b1, 35, 1'b0);
    run_phase(1'b1, 16'd3, 16'd5, 1'b0, 1'b1, 35, 1'b0);
    run_phase(1'b1, 16'd2, 16'd0, 1'b1, 1'b0, 35, 1'b1);
    run_phase(1'b1, 16'd0, 16'd2, 1'b1, 1'b1, 35, 1'b0);
    run_phase(1'b1, 16'd4, 16'd2, 1'b1, 1'b1, 35, 1'b0);
    run_phase(1'b0, 16'd3, 16'd3, 1'b1, 1'b1, 30, 1'b0);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 25, 1'b0);
    run_phase(1'b1, 16'd0, 16'd0, 1'b0, 1'b0, 30, 1'b0);
    repeat (4) begin
      run_phase(1'b1, 16'($urandom_range(0, 8)), 16'($urandom_range(0, 10)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 35, 1'b0);
    end

    // short countdown into display sleep with light sleep off
    drain();
    write_settings(1'b1, 16'd3, 16'd0, 1'b1, 1'b1);
    steady_send = 1'b1;
    send(any_item(CMD_APPLY, BLK_NONE));
    send(mk(CMD_ACTIVITY, SRC_INTERACTION, RSN_NONE, BLK_NONE));
    send(any_item(CMD_NO_MOTION, BLK_NONE));
    repeat (5) send(any_item(CMD_TICK, BLK_NONE));
    steady_send = 1'b0;

    // disabling wakes the display that is still asleep
    run_phase(1'b0, 16'd0, 16'd0, 1'b0, 1'b0, 20, 1'b0);
    drain();

    $display("run covered %0d commands, %0d results checked, %0d display and %0d light sleeps",
             sb.accepted, sb.checked, sb.disp_sleeps, sb.light_sleeps);
    $display("%0d wake events, %0d refused or ignored commands, peak inactive count %0d",
             sb.wakes, sb.refused, sb.peak_secs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_staged_inactivity_sleep_controller passed");
    end else begin
      $display("tb_staged_inactivity_sleep_controller failed");
    end
    $finish;
  end

endmodule

### staged_inactivity_sleep_controller.f
rtl/sisc_pkg.sv
rtl/staged_inactivity_sleep_controller.sv
tb/sv/tb_staged_inactivity_sleep_controller.sv
